// ----- hw/rtl/lpht_pkg.sv -----
// Shared types and constants for the linear probing hash table.
// Holds the operation and status codes, the control states and the port widths.
// Depends on nothing.
package lpht_pkg;

    // Default geometry of the table.
    localparam int TABLE_SIZE_DEF = 16;
    localparam int KEY_BITS_DEF   = 40;

    // Field widths of the stream beats.
    localparam int OP_W     = 2;
    localparam int IN_KEY_W = 40;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 8;

    // Bits of the key that are retired per cycle by the home slot reduction.
    localparam int DIGIT_W = 4;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_DELETE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_HOLD
    } state_t;

endpackage

// ----- hw/rtl/linear_probe_hash_table.sv -----
// Hash table with open addressing and linear probing; uses lpht_pkg and lpht_ram.
// The result beat is registered once the probe has read its 1 to TABLE_SIZE slots in turn,
// after ceil(KEY_BITS/4) digits of home slot reduction when TABLE_SIZE is not a power of two.
// An insert into a full table or an unused op answers from the hold state with no probe.
// Output stalls delay the result beat.
// Throughput: one item at a time, with the probe bound by the one slot read per cycle of the RAM.
// Reset: a clearing pass over every slot zeroes the valid bits; s_tready stays low meanwhile.
module linear_probe_hash_table
    import lpht_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // op [1:0], key [41:2], zero fill [47:42]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status [1:0], slot [5:2], zero fill [7:6]
);

    localparam int  IDX_W  = $clog2(TABLE_SIZE);
    localparam int  CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int  REM_W  = IDX_W;
    localparam int  NDIG   = (KEY_BITS + DIGIT_W - 1) / DIGIT_W;
    localparam int  KPAD   = NDIG * DIGIT_W;
    localparam int  DIG_W  = $clog2(NDIG);
    localparam int  ENT_W  = KEY_BITS + 1;
    localparam bit  POW2   = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
    localparam int  V_W    = REM_W + DIGIT_W;
    localparam int  RCP_S  = V_W + IDX_W;
    localparam int  M_W    = V_W + 1;
    localparam int  P_W    = V_W + M_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] TS_CNT   = CNT_W'(TABLE_SIZE);
    localparam logic [V_W-1:0]   TS_V     = V_W'(TABLE_SIZE);
    localparam logic [M_W-1:0]   RCP_M    =
        M_W'(((1 << RCP_S) + TABLE_SIZE - 1) / TABLE_SIZE);

    // One Horner step of the home slot reduction: (r * 2^DIGIT_W + d) mod TABLE_SIZE.
    // The quotient comes from a reciprocal multiplication that is exact over this range.
    function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] r,
                                                  input logic [DIGIT_W-1:0] d);
        logic [V_W-1:0] v;
        logic [P_W-1:0] prod;
        logic [V_W-1:0] q;
        logic [V_W-1:0] t;
        v    = {r, d};
        prod = {{M_W{1'b0}}, v} * {{V_W{1'b0}}, RCP_M};
        q    = V_W'(prod >> RCP_S);
        t    = v - q * TS_V;
        return t[REM_W-1:0];
    endfunction

    // Input fields.
    logic [OP_W-1:0]     s_op;
    logic [IN_KEY_W-1:0] s_key;
    logic [KEY_BITS-1:0] key_in;

    assign s_op   = s_tdata[OP_W-1:0];
    assign s_key  = s_tdata[OP_W +: IN_KEY_W];
    assign key_in = KEY_BITS'(s_key);

    // Registers.
    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [KPAD-1:0]     sh_reg, sh_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [DIG_W-1:0]    dig_reg, dig_next;
    logic [IDX_W-1:0]    pos_reg, pos_next;
    logic [IDX_W-1:0]    raddr_reg, raddr_next;
    logic                rvalid_reg, rvalid_next;
    logic [IDX_W-1:0]    eval_reg, eval_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    status_t             res_status_reg, res_status_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                m_tvalid_reg, m_tvalid_next;
    status_t             m_status_reg, m_status_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;

    // RAM ports.
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic [ENT_W-1:0] ram_rdata;

    lpht_ram #(
        .WIDTH(ENT_W),
        .DEPTH(TABLE_SIZE)
    ) u_slots (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_addr(pos_reg),
        .rd_data(ram_rdata)
    );

    // Evaluation of the slot that the RAM returns this cycle.
    logic             ent_valid;
    logic             is_ins;
    logic             is_del;
    logic             found;
    logic             exhausted;
    logic             decide;
    logic             out_free;
    logic             table_full;
    logic [IDX_W-1:0] pos_inc;
    status_t          dec_status;
    logic [IDX_W-1:0] dec_slot;

    assign ent_valid  = ram_rdata[KEY_BITS];
    assign is_ins     = op_reg == OP_INSERT;
    assign is_del     = op_reg == OP_DELETE;
    assign found      = (state_reg == ST_PROBE) && rvalid_reg &&
                        (is_ins ? !ent_valid
                                : (ent_valid && (ram_rdata[KEY_BITS-1:0] == key_reg)));
    assign exhausted  = (state_reg == ST_PROBE) && rvalid_reg && !found && (eval_reg == LAST_IDX);
    assign decide     = found || exhausted;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign table_full = count_reg >= TS_CNT;
    assign pos_inc    = (pos_reg == LAST_IDX) ? '0 : pos_reg + 1'b1;
    assign dec_status = found ? STAT_OK : (is_ins ? STAT_FULL : STAT_MISS);
    assign dec_slot   = found ? raddr_reg : '0;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (pos_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_op == OP_INSERT && table_full) begin
                        state_next = ST_HOLD;
                    end else if (s_op == OP_INSERT || s_op == OP_SEARCH || s_op == OP_DELETE) begin
                        state_next = POW2 ? ST_PROBE : ST_MOD;
                    end else begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_MOD: begin
                if (dig_reg == DIG_W'(NDIG - 1)) begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (decide) begin
                    state_next = out_free ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM access and result register.
    always_comb begin
        op_next         = op_reg;
        key_next        = key_reg;
        sh_next         = sh_reg;
        rem_next        = rem_reg;
        dig_next        = dig_reg;
        pos_next        = pos_reg;
        raddr_next      = raddr_reg;
        rvalid_next     = 1'b0;
        eval_next       = eval_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg;
        ram_wdata       = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                // Sweep the valid bits to zero, one slot a cycle.
                ram_we   = 1'b1;
                pos_next = pos_inc;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_op;
                    key_next        = key_in;
                    sh_next         = KPAD'(key_in);
                    rem_next        = '0;
                    dig_next        = '0;
                    pos_next        = IDX_W'(key_in);
                    eval_next       = '0;
                    res_slot_next   = '0;
                    res_status_next = (s_op == OP_INSERT) ? STAT_FULL : STAT_MISS;
                end
            end
            ST_MOD: begin
                // Reduce the key to its home slot, one digit a cycle.
                rem_next = mod_step(rem_reg, sh_reg[KPAD-1 -: DIGIT_W]);
                sh_next  = sh_reg << DIGIT_W;
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIG_W'(NDIG - 1)) begin
                    pos_next = IDX_W'(rem_next);
                end
            end
            ST_PROBE: begin
                // Issue one slot read per cycle and evaluate the one read before.
                rvalid_next = 1'b1;
                raddr_next  = pos_reg;
                pos_next    = pos_inc;
                if (decide) begin
                    rvalid_next     = 1'b0;
                    res_status_next = dec_status;
                    res_slot_next   = dec_slot;
                    ram_waddr       = raddr_reg;
                    if (found && is_ins) begin
                        ram_we     = 1'b1;
                        ram_wdata  = {1'b1, key_reg};
                        count_next = count_reg + 1'b1;
                    end else if (found && is_del) begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b0, key_reg};
                        if (count_reg != '0) begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end else if (rvalid_reg) begin
                    eval_next = eval_reg + 1'b1;
                end
            end
            ST_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    // Output register, loaded at the decision or from the held result.
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_slot_next   = m_slot_reg;
        if (state_reg == ST_PROBE && decide && out_free) begin
            m_tvalid_next = 1'b1;
            m_status_next = dec_status;
            m_slot_next   = SLOT_W'(dec_slot);
        end else if (state_reg == ST_HOLD && out_free) begin
            m_tvalid_next = 1'b1;
            m_status_next = res_status_reg;
            m_slot_next   = SLOT_W'(res_slot_reg);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            pos_reg      <= '0;
            rvalid_reg   <= 1'b0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            rvalid_reg   <= rvalid_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        sh_reg         <= sh_next;
        rem_reg        <= rem_next;
        dig_reg        <= dig_next;
        raddr_reg      <= raddr_next;
        eval_reg       <= eval_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_slot_reg     <= m_slot_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_DATA_W - STATUS_W - SLOT_W){1'b0}}, m_slot_reg, m_status_reg};

    // The entry count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= TS_CNT)
        else $error("entry count exceeds table size");

    // A successful insert raises the count by one.
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (found && is_ins) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not update the entry count");

    // A probe that runs out of slots leaves the table untouched.
    a_exhausted_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        exhausted |-> !ram_we)
        else $error("write on an exhausted probe");

    // The probe stops before it evaluates more slots than the table holds.
    a_eval_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE && rvalid_reg && !decide) |-> (eval_reg < LAST_IDX))
        else $error("probe ran past the last slot");

endmodule

// ----- hw/rtl/lpht_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the slot array of the hash table; depends on nothing.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- tb/sv/tb_linear_probe_hash_table.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the linear probing hash table: directed and random beats.
// Keeps a shadow copy of the table to predict each reply; depends on lpht_pkg and the RTL.
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int TABLE_SIZE  = TABLE_SIZE_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 40;
    localparam int IDLE_PCT    = 30;

    // Op code that the block must answer as a miss without touching the table.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
    } table_reply_t;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // Shadow of the table contents, updated as each input beat is accepted.
    logic [IN_KEY_W-1:0] shadow_key  [TABLE_SIZE];
    logic                shadow_used [TABLE_SIZE];
    int                  shadow_count = 0;

    table_reply_t expected_replies[$];
    int           mismatch_count = 0;
    int           stall_cycles   = 0;
    logic         no_idle        = 1'b0;

    linear_probe_hash_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Apply one operation to the shadow table and return the reply it must produce.
    function automatic table_reply_t apply_table_op(input logic [OP_W-1:0] op,
                                                    input logic [IN_KEY_W-1:0] key);
        table_reply_t reply;
        int           pos;
        int           hit;
        reply.status = STAT_MISS;
        reply.slot   = '0;
        hit          = -1;
        pos          = int'(key % TABLE_SIZE);
        if (op == OP_INSERT) begin
            // Insert takes the first free slot from home, unless the count is at capacity.
            if (shadow_count < TABLE_SIZE) begin
                for (int n = 0; n < TABLE_SIZE; n++) begin
                    if (hit < 0 && !shadow_used[pos])
                        hit = pos;
                    pos = (pos + 1) % TABLE_SIZE;
                end
            end
            if (hit < 0) begin
                reply.status = STAT_FULL;
            end else begin
                shadow_key[hit]  = key;
                shadow_used[hit] = 1'b1;
                shadow_count++;
                reply.status = STAT_OK;
                reply.slot   = SLOT_W'(hit);
            end
        end else if (op == OP_SEARCH || op == OP_DELETE) begin
            // Search and delete stop at the first occupied slot with an equal key.
            for (int n = 0; n < TABLE_SIZE; n++) begin
                if (hit < 0 && shadow_used[pos] && shadow_key[pos] == key)
                    hit = pos;
                pos = (pos + 1) % TABLE_SIZE;
            end
            if (hit >= 0) begin
                if (op == OP_DELETE) begin
                    shadow_used[hit] = 1'b0;
                    if (shadow_count > 0)
                        shadow_count--;
                end
                reply.status = STAT_OK;
                reply.slot   = SLOT_W'(hit);
            end
        end
        return reply;
    endfunction

    // Random key: often one that is stored now, otherwise fresh, sometimes clustered
    // around the top and bottom home slots so that probes wrap around.
    function automatic logic [IN_KEY_W-1:0] pick_key(input int stored_pct);
        logic [IN_KEY_W-1:0] key;
        int                  stored[$];
        key = IN_KEY_W'({$urandom, $urandom});
        for (int i = 0; i < TABLE_SIZE; i++)
            if (shadow_used[i])
                stored.push_back(i);
        if (stored.size() != 0 && $urandom_range(99) < stored_pct)
            key = shadow_key[stored[$urandom_range(stored.size() - 1)]];
        else if ($urandom_range(1) == 1)
            key[SLOT_W-1:0] = SLOT_W'($urandom_range(13, 17));
        return key;
    endfunction

    // Send one beat and record its expected reply once it is accepted.
    task automatic send_op(input logic [OP_W-1:0] op, input logic [IN_KEY_W-1:0] key);
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - OP_W - IN_KEY_W){1'b0}}, key, op};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        expected_replies.push_back(apply_table_op(op, key));
    endtask

    // Random mix of operations with the given percentages; the rest is the unused op.
    task automatic run_mix(input int count, input int ins_pct, input int srch_pct,
                           input int del_pct);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < ins_pct)
                send_op(OP_INSERT, pick_key(20));
            else if (r < ins_pct + srch_pct)
                send_op(OP_SEARCH, pick_key(70));
            else if (r < ins_pct + srch_pct + del_pct)
                send_op(OP_DELETE, pick_key(70));
            else
                send_op(OP_UNUSED, pick_key(50));
        end
    endtask

    // Lookups and the unused op on a freshly cleared table all miss.
    task automatic test_empty_table();
        send_op(OP_SEARCH, '0);
        send_op(OP_DELETE, '1);
        send_op(OP_UNUSED, '1);
    endtask

    // Keys at both extremes, a duplicate that wraps past the last slot, and removal.
    task automatic test_basic_ops();
        send_op(OP_INSERT, '0);
        send_op(OP_INSERT, '1);
        send_op(OP_INSERT, '1);
        send_op(OP_SEARCH, '1);
        send_op(OP_DELETE, '1);
        send_op(OP_SEARCH, '1);
        send_op(OP_DELETE, '1);
        send_op(OP_SEARCH, '1);
        send_op(OP_UNUSED, '0);
        send_op(OP_SEARCH, '0);
    endtask

    // Fill every slot from one home slot, delete an absent key, then hit the full case twice.
    task automatic test_fill_to_full();
        logic [IN_KEY_W-1:0] key;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            key = IN_KEY_W'({$urandom, $urandom});
            key[SLOT_W-1:0] = '1;
            send_op(OP_INSERT, key);
        end
        send_op(OP_DELETE, '0);
        send_op(OP_INSERT, key);
        send_op(OP_INSERT, '0);
    endtask

    task automatic test_random_fill();
        run_mix(150, 65, 20, 12);
    endtask

    task automatic test_random_churn();
        run_mix(150, 40, 30, 27);
    endtask

    // A long stretch with neither side idling.
    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_mix(150, 40, 30, 27);
        no_idle = 1'b0;
    endtask

    task automatic test_random_drain();
        run_mix(150, 20, 25, 52);
    endtask

    // Check each reply beat against the oldest expectation and pick the next ready.
    always @(posedge aclk) begin
        table_reply_t exp_reply;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_replies.size() == 0) begin
                $error("unexpected reply beat: status %0d, slot %0d",
                       m_tdata[STATUS_W-1:0], m_tdata[STATUS_W +: SLOT_W]);
                mismatch_count++;
            end else begin
                exp_reply = expected_replies.pop_front();
                if (m_tdata[STATUS_W-1:0] !== exp_reply.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_reply.status, m_tdata[STATUS_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[STATUS_W +: SLOT_W] !== exp_reply.slot) begin
                    $error("slot mismatch: expected %0d, actual %0d",
                           exp_reply.slot, m_tdata[STATUS_W +: SLOT_W]);
                    mismatch_count++;
                end
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: too many cycles without any beat on either side ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            shadow_used[i] = 1'b0;
            shadow_key[i]  = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_basic_ops();
        test_fill_to_full();
        test_random_fill();
        test_random_churn();
        test_back_to_back();
        test_random_drain();
        s_tvalid <= 1'b0;

        // Let the last replies arrive, then watch for stray beats.
        while (expected_replies.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
